>>> design/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, character constants, reason codes and character class
// helpers for the token context classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

    // one unicode code point
    typedef logic [20:0] cp_t;

    // verdict reason codes
    typedef enum logic [3:0] {
        RSN_NONE    = 4'd0,
        RSN_CHORD   = 4'd1,
        RSN_URL     = 4'd2,
        RSN_EMAIL   = 4'd3,
        RSN_PATH    = 4'd4,
        RSN_IDENT   = 4'd5,
        RSN_VERHASH = 4'd6,
        RSN_SHELL   = 4'd7,
        RSN_BYPASS  = 4'd8
    } tcc_reason_t;

    // ascii characters used by the recognizers
    localparam cp_t CH_COLON  = 21'h3A;
    localparam cp_t CH_SLASH  = 21'h2F;
    localparam cp_t CH_BSLASH = 21'h5C;
    localparam cp_t CH_MINUS  = 21'h2D;
    localparam cp_t CH_DOLLAR = 21'h24;
    localparam cp_t CH_PCT    = 21'h25;
    localparam cp_t CH_EQUAL  = 21'h3D;
    localparam cp_t CH_AMP    = 21'h26;
    localparam cp_t CH_PIPE   = 21'h7C;
    localparam cp_t CH_AT     = 21'h40;
    localparam cp_t CH_DOT    = 21'h2E;
    localparam cp_t CH_UNDER  = 21'h5F;
    localparam cp_t CH_PLUS   = 21'h2B;
    localparam cp_t CH_LV     = 21'h76;
    localparam cp_t CH_UV     = 21'h56;
    localparam cp_t CH_LA     = 21'h61;
    localparam cp_t CH_LF     = 21'h66;
    localparam cp_t CH_LZ     = 21'h7A;
    localparam cp_t CH_UA     = 21'h41;
    localparam cp_t CH_UF     = 21'h46;
    localparam cp_t CH_UZ     = 21'h5A;
    localparam cp_t CH_D0     = 21'h30;
    localparam cp_t CH_D9     = 21'h39;
    localparam cp_t CASE_OFS  = 21'h20;

    // saturation limits
    localparam logic [2:0] LEN_MAX   = 3'd7;
    localparam logic [3:0] V6_GRP_MAX = 4'd9;
    localparam logic [2:0] V6_DIG_MAX = 3'd5;
    localparam logic [2:0] V6_DIG_OK  = 3'd4;
    localparam logic [3:0] V6_FULL    = 4'd8;
    localparam logic [1:0] DOTS_MAX   = 2'd2;
    localparam int         NUM_PFX    = 4;

    // ipv6 group tracker
    typedef struct packed {
        logic [3:0] grp;
        logic [2:0] dig;
        logic       comp;
        logic       pend;
        logic       fail;
    } tcc_v6_t;

    // identifier tracker
    typedef struct packed {
        logic ltr;
        logic dig;
        logic pun;
        logic trn;
        logic plo;
        logic pend;
        logic fail;
    } tcc_id_t;

    // version and hex tracker
    typedef struct packed {
        logic       vok;
        logic [1:0] dots;
        logic       vdig;
        logic       hok;
        logic       hdig;
        logic       hlet;
    } tcc_vh_t;

    // full recognizer state of one token
    typedef struct packed {
        logic [2:0]         len;
        cp_t                rc0;
        cp_t                rc1;
        logic [NUM_PFX-1:0] pfx;
        logic               url;
        logic               path;
        logic               shell;
        logic               em_at;
        logic               em_bad;
        tcc_v6_t            v6;
        tcc_id_t            id;
        tcc_vh_t            vh;
    } tcc_state_t;

    function automatic tcc_state_t reset_state();
        tcc_state_t s;
        s        = '0;
        s.pfx    = '1;
        s.vh.vok = 1'b1;
        s.vh.hok = 1'b1;
        return s;
    endfunction

    function automatic logic is_lower(input cp_t c);
        return (c >= CH_LA) && (c <= CH_LZ);
    endfunction

    function automatic logic is_upper(input cp_t c);
        return (c >= CH_UA) && (c <= CH_UZ);
    endfunction

    function automatic logic is_letter(input cp_t c);
        return is_lower(c) || is_upper(c);
    endfunction

    function automatic logic is_digit(input cp_t c);
        return (c >= CH_D0) && (c <= CH_D9);
    endfunction

    function automatic logic is_hex_letter(input cp_t c);
        return ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    function automatic logic is_hex(input cp_t c);
        return is_digit(c) || is_hex_letter(c);
    endfunction

    function automatic cp_t to_lower(input cp_t c);
        return is_upper(c) ? c + CASE_OFS : c;
    endfunction

    // length of each url prefix: www. http: https: ftp:
    function automatic logic [2:0] prefix_len(input logic [1:0] p);
        logic [2:0] n;
        case (p)
            2'd0:    n = 3'd4;
            2'd1:    n = 3'd5;
            2'd2:    n = 3'd6;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

    // character at position i of url prefix p
    function automatic cp_t prefix_char(input logic [1:0] p, input logic [2:0] i);
        logic [7:0] ch;
        ch = 8'h00;
        case (p)
            2'd0: begin
                case (i)
                    3'd0, 3'd1, 3'd2: ch = 8'h77;
                    3'd3:             ch = 8'h2E;
                    default:          ch = 8'h00;
                endcase
            end
            2'd1: begin
                case (i)
                    3'd0:       ch = 8'h68;
                    3'd1, 3'd2: ch = 8'h74;
                    3'd3:       ch = 8'h70;
                    3'd4:       ch = 8'h3A;
                    default:    ch = 8'h00;
                endcase
            end
            2'd2: begin
                case (i)
                    3'd0:       ch = 8'h68;
                    3'd1, 3'd2: ch = 8'h74;
                    3'd3:       ch = 8'h70;
                    3'd4:       ch = 8'h73;
                    3'd5:       ch = 8'h3A;
                    default:    ch = 8'h00;
                endcase
            end
            default: begin
                case (i)
                    3'd0:    ch = 8'h66;
                    3'd1:    ch = 8'h74;
                    3'd2:    ch = 8'h70;
                    3'd3:    ch = 8'h3A;
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return 21'(ch);
    endfunction

endpackage

`default_nettype wire

>>> design/tcc_recog.sv
// ----------------------------------------------------------------------------
// tcc_recog
// Running recognizers: holds the per-token state and computes its update
// for the incoming code point. The state returns to reset after a verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_recog (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                item_take,   // item accepted this cycle
    input  wire logic                item_end,    // item closes the token
    input  wire tcc_pkg::cp_t        code_point,
    output tcc_pkg::tcc_state_t      st_next      // state including this item
);

    tcc_pkg::tcc_state_t st_reg;

    // per-character update of every recognizer
    always_comb begin
        tcc_pkg::cp_t c;
        logic [2:0]   i;
        logic [3:0]   g;
        logic [2:0]   d;
        logic         comp;
        logic         pend;
        logic         fail;
        logic         done;

        c       = code_point;
        i       = st_reg.len;
        st_next = st_reg;
        g       = st_reg.v6.grp;
        d       = st_reg.v6.dig;
        comp    = st_reg.v6.comp;
        pend    = st_reg.v6.pend;
        fail    = 1'b0;
        done    = 1'b0;

        // url prefixes, case-insensitive
        for (int p = 0; p < tcc_pkg::NUM_PFX; p++) begin
            if ((i < tcc_pkg::prefix_len(2'(p))) &&
                (tcc_pkg::to_lower(c) != tcc_pkg::prefix_char(2'(p), i))) begin
                st_next.pfx[p] = 1'b0;
            end
        end

        // scheme separator, path and shell marks
        if ((st_reg.rc1 == tcc_pkg::CH_COLON) && (st_reg.rc0 == tcc_pkg::CH_SLASH) &&
            (c == tcc_pkg::CH_SLASH)) begin
            st_next.url = 1'b1;
        end
        if ((c == tcc_pkg::CH_SLASH) || (c == tcc_pkg::CH_BSLASH)) begin
            st_next.path = 1'b1;
        end
        if (((i == 3'd0) && ((c == tcc_pkg::CH_MINUS) || (c == tcc_pkg::CH_DOLLAR) ||
                             (c == tcc_pkg::CH_PCT))) ||
            (c == tcc_pkg::CH_EQUAL) ||
            ((st_reg.rc0 == tcc_pkg::CH_AMP) && (c == tcc_pkg::CH_AMP)) ||
            ((st_reg.rc0 == tcc_pkg::CH_PIPE) && (c == tcc_pkg::CH_PIPE))) begin
            st_next.shell = 1'b1;
        end

        // e-mail
        if (c == tcc_pkg::CH_AT) begin
            if (st_reg.em_at || (i == 3'd0)) begin
                st_next.em_bad = 1'b1;
            end
            st_next.em_at = 1'b1;
        end else if (!(tcc_pkg::is_letter(c) || tcc_pkg::is_digit(c) ||
                       (c == tcc_pkg::CH_DOT) || (c == tcc_pkg::CH_UNDER) ||
                       (c == tcc_pkg::CH_MINUS) || (c == tcc_pkg::CH_PLUS))) begin
            st_next.em_bad = 1'b1;
        end

        // ipv6 groups, colon pairs resolved one character late
        if (!st_reg.v6.fail) begin
            if (pend) begin
                pend = 1'b0;
                if (c == tcc_pkg::CH_COLON) begin
                    if (comp) begin
                        fail = 1'b1;
                    end
                    comp = 1'b1;
                    if (d != 3'd0) begin
                        if (g < tcc_pkg::V6_GRP_MAX) begin
                            g = g + 4'd1;
                        end
                        d = 3'd0;
                    end
                    done = 1'b1;
                end else begin
                    if (d == 3'd0) begin
                        fail = 1'b1;
                    end
                    if (g < tcc_pkg::V6_GRP_MAX) begin
                        g = g + 4'd1;
                    end
                    d = 3'd0;
                end
            end
            if (!done && !fail) begin
                if (tcc_pkg::is_hex(c)) begin
                    if (d < tcc_pkg::V6_DIG_MAX) begin
                        d = d + 3'd1;
                    end
                    if (d > tcc_pkg::V6_DIG_OK) begin
                        fail = 1'b1;
                    end
                end else if (c == tcc_pkg::CH_COLON) begin
                    pend = 1'b1;
                end else begin
                    fail = 1'b1;
                end
            end
            st_next.v6.grp  = g;
            st_next.v6.dig  = d;
            st_next.v6.comp = comp;
            st_next.v6.pend = pend;
            st_next.v6.fail = fail;
        end

        // identifier
        if (!st_reg.id.fail) begin
            if (st_reg.id.pend) begin
                st_next.id.pend = 1'b0;
                if (c == tcc_pkg::CH_COLON) begin
                    st_next.id.pun = 1'b1;
                end else begin
                    st_next.id.fail = 1'b1;
                end
            end else if (tcc_pkg::is_letter(c)) begin
                st_next.id.ltr = 1'b1;
                if (st_reg.id.plo && tcc_pkg::is_upper(c)) begin
                    st_next.id.trn = 1'b1;
                end
                st_next.id.plo = tcc_pkg::is_lower(c);
            end else begin
                st_next.id.plo = 1'b0;
                if (tcc_pkg::is_digit(c)) begin
                    st_next.id.dig = 1'b1;
                end else if (c == tcc_pkg::CH_UNDER) begin
                    st_next.id.pun = 1'b1;
                end else if (c == tcc_pkg::CH_COLON) begin
                    st_next.id.pend = 1'b1;
                end else begin
                    st_next.id.fail = 1'b1;
                end
            end
        end

        // version track skips a leading v
        if (!((i == 3'd0) && ((c == tcc_pkg::CH_LV) || (c == tcc_pkg::CH_UV))) &&
            st_reg.vh.vok) begin
            if (c == tcc_pkg::CH_DOT) begin
                if (st_reg.vh.dots < tcc_pkg::DOTS_MAX) begin
                    st_next.vh.dots = st_reg.vh.dots + 2'd1;
                end
            end else if (tcc_pkg::is_digit(c)) begin
                st_next.vh.vdig = 1'b1;
            end else begin
                st_next.vh.vok = 1'b0;
            end
        end

        // hex track
        if (!tcc_pkg::is_hex(c)) begin
            st_next.vh.hok = 1'b0;
        end
        if (tcc_pkg::is_digit(c)) begin
            st_next.vh.hdig = 1'b1;
        end
        if (tcc_pkg::is_hex_letter(c)) begin
            st_next.vh.hlet = 1'b1;
        end

        // history and length
        st_next.rc1 = st_reg.rc0;
        st_next.rc0 = c;
        if (i < tcc_pkg::LEN_MAX) begin
            st_next.len = i + 3'd1;
        end
    end

    // token state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= tcc_pkg::reset_state();
        end else if (item_take) begin
            if (item_end) begin
                st_reg <= tcc_pkg::reset_state();
            end else begin
                st_reg <= st_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/tcc_verdict.sv
// ----------------------------------------------------------------------------
// tcc_verdict
// Turns the final recognizer state into a reason code, checking the reasons
// in their fixed priority.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_verdict (
    input  wire tcc_pkg::tcc_state_t st,
    input  wire logic             empty_token,
    input  wire logic             chord_held,
    input  wire logic             app_bypass,
    output tcc_pkg::tcc_reason_t  reason
);

    logic url;
    logic v6;
    logic version;
    logic hex;
    logic vh;
    logic ident;

    // url: scheme separator or a complete prefix
    always_comb begin
        url = st.url;
        for (int p = 0; p < tcc_pkg::NUM_PFX; p++) begin
            if (st.pfx[p] && (st.len >= tcc_pkg::prefix_len(2'(p)))) begin
                url = 1'b1;
            end
        end
    end

    // ipv6: close a pending single colon, then count groups
    always_comb begin
        logic [3:0] g;
        logic [2:0] d;
        logic       fail;
        logic       grp_ok;

        g    = st.v6.grp;
        d    = st.v6.dig;
        fail = st.v6.fail;
        if (!fail && st.v6.pend) begin
            if (d == 3'd0) begin
                fail = 1'b1;
            end
            if (g < tcc_pkg::V6_GRP_MAX) begin
                g = g + 4'd1;
            end
            d = 3'd0;
        end
        grp_ok = 1'b1;
        if (d != 3'd0) begin
            if (g < tcc_pkg::V6_GRP_MAX) begin
                g = g + 4'd1;
            end
        end else if (!st.v6.comp || (st.rc0 != tcc_pkg::CH_COLON) ||
                     (st.rc1 != tcc_pkg::CH_COLON)) begin
            grp_ok = 1'b0;
        end
        v6 = !fail && (st.len >= 3'd2) && grp_ok &&
             (st.v6.comp ? (g < tcc_pkg::V6_FULL) : (g == tcc_pkg::V6_FULL));
    end

    // version, hash and identifier
    assign version = st.vh.vok && st.vh.vdig && (st.vh.dots >= tcc_pkg::DOTS_MAX);
    assign hex     = (st.len >= tcc_pkg::LEN_MAX) && st.vh.hok && st.vh.hdig && st.vh.hlet;
    assign vh      = v6 || version || hex;
    assign ident   = !v6 && !st.id.fail && !st.id.pend &&
                     (st.id.pun || st.id.trn || (st.id.ltr && st.id.dig && !vh));

    // priority encode
    always_comb begin
        if (chord_held) begin
            reason = tcc_pkg::RSN_CHORD;
        end else if (empty_token) begin
            reason = tcc_pkg::RSN_NONE;
        end else if (url) begin
            reason = tcc_pkg::RSN_URL;
        end else if (st.em_at && !st.em_bad) begin
            reason = tcc_pkg::RSN_EMAIL;
        end else if (st.path) begin
            reason = tcc_pkg::RSN_PATH;
        end else if (ident) begin
            reason = tcc_pkg::RSN_IDENT;
        end else if (vh) begin
            reason = tcc_pkg::RSN_VERHASH;
        end else if (st.shell) begin
            reason = tcc_pkg::RSN_SHELL;
        end else begin
            reason = tcc_pkg::RSN_NONE;
        end
        if ((reason == tcc_pkg::RSN_NONE) && app_bypass) begin
            reason = tcc_pkg::RSN_BYPASS;
        end
    end

endmodule

`default_nettype wire

>>> design/token_context_classifier_top.sv
// ----------------------------------------------------------------------------
// token_context_classifier_top
// Classifies a token fed one code point per item and returns one verdict
// item per token.
// ----------------------------------------------------------------------------
// The block takes one item per clock. Every item updates the token state
// register in the cycle it is accepted; the item that carries tlast (or the
// empty-token flag in tuser) produces its verdict in the result register, so
// the verdict appears on the m_ side in the cycle after the item is accepted.
// Throughput is one item per cycle, set by the single state register loop;
// s_tready only drops in reset or while a verdict waits and m_tready is low.
// Modifier chord and application bypass come from the item ending the token.
`default_nettype none

module token_context_classifier_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [20:0] code_point, [21] chord_held,
                                        // [22] app_bypass, [23] zero
    input  wire logic        s_tlast,   // last_char
    input  wire logic        s_tuser,   // [0] empty_token
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [0] allowed, [4:1] reason_code, [7:5] zero
);

    tcc_pkg::tcc_state_t  st_next;
    tcc_pkg::tcc_reason_t reason;
    logic                 item_take;
    logic                 item_end;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [3:0]           out_reason_reg;

    // input handshake
    assign s_tready  = aresetn && (!out_valid_reg || m_tready);
    assign item_take = s_tvalid && s_tready;
    assign item_end  = s_tlast || s_tuser;

    tcc_recog u_recog (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_take  (item_take),
        .item_end   (item_end),
        .code_point (s_tdata[20:0]),
        .st_next    (st_next)
    );

    tcc_verdict u_verdict (
        .st          (st_next),
        .empty_token (s_tuser),
        .chord_held  (s_tdata[21]),
        .app_bypass  (s_tdata[22]),
        .reason      (reason)
    );

    // result register valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (item_take && item_end) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (item_take && item_end) begin
            out_reason_reg <= reason;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reason_reg, (out_reason_reg == tcc_pkg::RSN_NONE)};

endmodule

`default_nettype wire

>>> design/tcc_checker.sv
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks of the classifier, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [23:0] s_tdata,
    input wire logic        s_tlast,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata
);

    logic s_take;
    logic m_free;

    assign s_take = s_tvalid && s_tready;
    assign m_free = !m_tvalid || m_tready;

    // a stalled verdict holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("verdict changed while stalled");

    // allowed agrees with the reason code
    a_allowed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[4:1] == tcc_pkg::RSN_NONE)))
        else $error("allowed does not match reason");

    // reason code stays within its range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4:1] <= tcc_pkg::RSN_BYPASS))
        else $error("reason code out of range");

    // a held chord always wins
    a_chord: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take && (s_tlast || s_tuser) && s_tdata[21]
        |=> m_tvalid && (m_tdata[4:1] == tcc_pkg::RSN_CHORD))
        else $error("chord verdict missing");

    // an inner character gives no verdict
    a_inner: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take && !s_tlast && !s_tuser && m_free |=> !m_tvalid)
        else $error("verdict without end of token");

endmodule

bind token_context_classifier_top tcc_checker u_tcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
